// File: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the parser.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KVP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kvp assertion failed");

// next-cycle implication
`define KVP_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kvp assertion failed");

`endif

// File: hw/rtl/kvp_pkg.sv
// Package of the key-value record parser: widths, parse phases, error codes
// and the result transaction type. No dependencies.
package kvp_pkg;

   localparam int MAX_LENGTH_BYTES = 4;
   localparam int KEY_ACC_BYTES    = 8;
   localparam int LEN_W            = 7 * MAX_LENGTH_BYTES;
   localparam int POS_W            = 17;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);

   localparam logic [POS_W-1:0] MAX_BUF_BYTES = 17'h10000;

   typedef enum logic [2:0] {
      PH_LENGTH,
      PH_HEADER,
      PH_KEY,
      PH_VALUE,
      PH_SKIP
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_BAD_LENGTH,
      ERR_KEY_LONG,
      ERR_TRUNCATED,
      ERR_BUF_LIMIT
   } err_code_type;

   typedef struct packed {
      logic [14:0]  record_index;
      logic [15:0]  record_begin;
      logic [16:0]  record_end;
      logic [16:0]  value_begin;
      logic         key_is_string;
      logic [6:0]   key_length;
      logic [63:0]  key_number;
      err_code_type error_code;
      logic         buffer_done;
      logic [15:0]  record_count;
   } result_type;

endpackage

// File: hw/rtl/kvp_front.sv
// Front end of the parser: accepts bytes, tracks the record parse state and
// pushes one result transaction per completed record or error. Uses kvp_pkg.
module kvp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          byte_in,
   input  logic                last_in_buffer,
   output logic                push_valid,
   output kvp_pkg::result_type push_data
);
   import kvp_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic [2:0]         lcount_ff, lcount_in;
   logic [LEN_W-1:0]   payload_ff, payload_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [POS_W-1:0]   begin_ff, begin_in;
   logic [POS_W-1:0]   vpos_ff, vpos_in;
   logic [6:0]         klen_ff, klen_in;
   logic               kstr_ff, kstr_in;
   logic [6:0]         seen_ff, seen_in;
   logic [63:0]        kacc_ff, kacc_in;
   logic [15:0]        records_ff, records_in;

   logic               skip;
   logic               limit_hit;
   logic [LEN_W-1:0]   length_next;
   logic [2:0]         lcount_next;
   logic [LEN_W-1:0]   payload_dec;
   logic [6:0]         hdr_klen;
   logic [6:0]         seen_next;
   logic [63:0]        kacc_next;
   logic [POS_W-1:0]   begin_eff;
   logic [POS_W-1:0]   position_inc;
   logic [15:0]        records_inc;
   logic               rec_done;
   err_code_type       err;

   always_comb begin
      skip         = (phase_ff == PH_SKIP);
      limit_hit    = (position_ff >= MAX_BUF_BYTES);
      length_next  = {length_ff[LEN_W-8:0], byte_in[6:0]};
      lcount_next  = lcount_ff + 3'd1;
      payload_dec  = payload_ff - LEN_W'(1);
      hdr_klen     = byte_in[6:0];
      seen_next    = seen_ff + 7'd1;
      kacc_next    = (seen_ff < 7'(KEY_ACC_BYTES)) ? {kacc_ff[55:0], byte_in} : kacc_ff;
      begin_eff    = (phase_ff == PH_LENGTH && lcount_ff == 3'd0) ? position_ff : begin_ff;
      position_inc = position_ff + POS_W'(1);
      records_inc  = (records_ff != 16'hFFFF) ? records_ff + 16'd1 : records_ff;
      rec_done     = 1'b0;
      err          = ERR_NONE;
      if (limit_hit) begin
         err = ERR_BUF_LIMIT;
      end else begin
         case (phase_ff) inside
            PH_LENGTH: begin
               if (byte_in[7] && lcount_next >= 3'(MAX_LENGTH_BYTES)) begin
                  err = ERR_BAD_LENGTH;
               end else if (!byte_in[7] && length_next == '0) begin
                  err = ERR_BAD_LENGTH;
               end
            end
            PH_HEADER: begin
               if (LEN_W'(hdr_klen) > payload_dec) begin
                  err = ERR_KEY_LONG;
               end else begin
                  rec_done = (payload_dec == '0);
               end
            end
            PH_KEY, PH_VALUE: begin
               rec_done = (payload_dec == '0);
            end
            default: begin
            end
         endcase
         if (err == ERR_NONE && !rec_done && last_in_buffer) begin
            err = ERR_TRUNCATED;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (skip || err != ERR_NONE) begin
            phase_in = last_in_buffer ? PH_LENGTH : PH_SKIP;
         end else if (rec_done) begin
            phase_in = PH_LENGTH;
         end else begin
            unique case (phase_ff) inside
               PH_LENGTH: phase_in = byte_in[7] ? PH_LENGTH : PH_HEADER;
               PH_HEADER: phase_in = (hdr_klen != 7'd0) ? PH_KEY : PH_VALUE;
               PH_KEY:    phase_in = (seen_next >= klen_ff) ? PH_VALUE : PH_KEY;
               PH_VALUE:  phase_in = PH_VALUE;
               default:   phase_in = PH_LENGTH;
            endcase
         end
      end
   end

   always_comb begin
      length_in   = length_ff;
      lcount_in   = lcount_ff;
      payload_in  = payload_ff;
      position_in = position_ff;
      begin_in    = begin_ff;
      vpos_in     = vpos_ff;
      klen_in     = klen_ff;
      kstr_in     = kstr_ff;
      seen_in     = seen_ff;
      kacc_in     = kacc_ff;
      records_in  = records_ff;
      if (fire && !(skip && !last_in_buffer)) begin
         if (!skip) begin
            begin_in = begin_eff;
         end
         if (skip || (err != ERR_NONE && last_in_buffer) || (rec_done && last_in_buffer)) begin
            length_in   = '0;
            lcount_in   = '0;
            payload_in  = '0;
            klen_in     = '0;
            kstr_in     = 1'b0;
            seen_in     = '0;
            kacc_in     = '0;
            position_in = '0;
            begin_in    = '0;
            vpos_in     = '0;
            records_in  = '0;
         end else if (err != ERR_NONE) begin
            position_in = position_ff;
         end else if (rec_done) begin
            length_in   = '0;
            lcount_in   = '0;
            payload_in  = '0;
            klen_in     = '0;
            kstr_in     = 1'b0;
            seen_in     = '0;
            kacc_in     = '0;
            records_in  = records_inc;
            position_in = position_inc;
         end else begin
            position_in = position_inc;
            case (phase_ff) inside
               PH_LENGTH: begin
                  length_in = length_next;
                  lcount_in = lcount_next;
                  if (!byte_in[7]) begin
                     payload_in = length_next;
                  end
               end
               PH_HEADER: begin
                  kstr_in    = byte_in[7];
                  klen_in    = hdr_klen;
                  payload_in = payload_dec;
                  seen_in    = '0;
                  kacc_in    = '0;
                  vpos_in    = position_inc + POS_W'(hdr_klen);
               end
               PH_KEY: begin
                  kacc_in    = kacc_next;
                  seen_in    = seen_next;
                  payload_in = payload_dec;
               end
               default: begin
                  payload_in = payload_dec;
               end
            endcase
         end
      end
   end

   always_comb begin
      push_valid                = fire && !skip && (err != ERR_NONE || rec_done);
      push_data.record_index    = records_ff[14:0];
      push_data.record_begin    = begin_eff[15:0];
      push_data.error_code      = err;
      push_data.buffer_done     = last_in_buffer;
      push_data.record_end      = '0;
      push_data.value_begin     = '0;
      push_data.key_is_string   = 1'b0;
      push_data.key_length      = '0;
      push_data.key_number      = '0;
      push_data.record_count    = records_ff;
      if (err == ERR_NONE) begin
         push_data.record_end   = position_inc;
         push_data.record_count = records_inc;
         if (phase_ff == PH_HEADER) begin
            push_data.value_begin   = position_inc + POS_W'(hdr_klen);
            push_data.key_is_string = byte_in[7];
            push_data.key_length    = hdr_klen;
         end else if (phase_ff == PH_KEY) begin
            push_data.value_begin   = vpos_ff;
            push_data.key_is_string = kstr_ff;
            push_data.key_length    = klen_ff;
            push_data.key_number    = kacc_next;
         end else begin
            push_data.value_begin   = vpos_ff;
            push_data.key_is_string = kstr_ff;
            push_data.key_length    = klen_ff;
            push_data.key_number    = kacc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LENGTH;
         length_ff   <= '0;
         lcount_ff   <= '0;
         payload_ff  <= '0;
         position_ff <= '0;
         begin_ff    <= '0;
         vpos_ff     <= '0;
         klen_ff     <= '0;
         kstr_ff     <= 1'b0;
         seen_ff     <= '0;
         kacc_ff     <= '0;
         records_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         length_ff   <= length_in;
         lcount_ff   <= lcount_in;
         payload_ff  <= payload_in;
         position_ff <= position_in;
         begin_ff    <= begin_in;
         vpos_ff     <= vpos_in;
         klen_ff     <= klen_in;
         kstr_ff     <= kstr_in;
         seen_ff     <= seen_in;
         kacc_ff     <= kacc_in;
         records_ff  <= records_in;
      end
   end

endmodule

// File: hw/rtl/kvp_queue.sv
// Short result queue between parser front end and output stage.
// Uses kvp_pkg for the transaction type and depth.
module kvp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  kvp_pkg::result_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                pop_valid,
   output kvp_pkg::result_type pop_data
);
   import kvp_pkg::*;

   result_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;
   logic                  do_pop;

   always_comb begin
      full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      pop_valid = (count_ff != '0);
      pop_data  = entry_ff[rd_ptr_ff];
      do_pop    = pop && pop_valid;
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push_valid) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/kvp_back.sv
// Output stage: holds the selected-index register, finishes each result
// transaction and drives the result register. Uses kvp_pkg.
module kvp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [14:0]         csr_wr_data,
   input  logic                q_valid,
   input  kvp_pkg::result_type q_data,
   output logic                q_pop,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output kvp_pkg::result_type rsp_data,
   output logic                rsp_selected
);
   import kvp_pkg::*;

   logic [14:0] sel_ff, sel_in;
   logic        valid_ff, valid_in;
   result_type  data_ff, data_in;
   logic        selected_ff, selected_in;
   logic        load;

   always_comb begin
      sel_in      = csr_wr_en ? csr_wr_data : sel_ff;
      load        = !valid_ff || !rsp_stall;
      q_pop       = load && q_valid;
      valid_in    = load ? q_valid : valid_ff;
      data_in     = data_ff;
      selected_in = selected_ff;
      if (q_pop) begin
         data_in = q_data;
         if (q_data.key_is_string) begin
            data_in.key_number = '0;
         end
         selected_in = (q_data.error_code == ERR_NONE) && (q_data.record_index == sel_ff);
      end
      rsp_valid    = valid_ff;
      rsp_data     = data_ff;
      rsp_selected = selected_ff;
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      selected_ff <= selected_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: hw/rtl/kv_record_stream_parser_unit.sv
// Key-value record stream parser, top level: front end, result queue, output stage.
// Throughput: one byte per cycle; each result passes through the result queue and
// then the output register before it shows on rsp_. Input stalls only when
// the four-entry result queue is full. Synchronous active-high reset empties
// the queue and restarts the parse at position 0; selected_index resets to 0.
module kv_record_stream_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [14:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_last_in_buffer,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_record_index,
   output logic [15:0] rsp_record_begin,
   output logic [16:0] rsp_record_end,
   output logic [16:0] rsp_value_begin,
   output logic        rsp_key_is_string,
   output logic [6:0]  rsp_key_length,
   output logic [63:0] rsp_key_number,
   output logic        rsp_is_selected,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_buffer_done,
   output logic [15:0] rsp_record_count
);
   import kvp_pkg::*;

   logic       fire;
   logic       push_valid;
   result_type push_data;
   logic       q_full;
   logic       q_valid;
   result_type q_data;
   logic       q_pop;
   result_type out_data;

   assign fire      = req_valid && !q_full;
   assign req_stall = q_full;

   kvp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .byte_in        (req_byte_in),
      .last_in_buffer (req_last_in_buffer),
      .push_valid     (push_valid),
      .push_data      (push_data)
   );

   kvp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (q_pop),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   kvp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (out_data),
      .rsp_selected (rsp_is_selected)
   );

   assign rsp_record_index  = out_data.record_index;
   assign rsp_record_begin  = out_data.record_begin;
   assign rsp_record_end    = out_data.record_end;
   assign rsp_value_begin   = out_data.value_begin;
   assign rsp_key_is_string = out_data.key_is_string;
   assign rsp_key_length    = out_data.key_length;
   assign rsp_key_number    = out_data.key_number;
   assign rsp_error_code    = out_data.error_code;
   assign rsp_buffer_done   = out_data.buffer_done;
   assign rsp_record_count  = out_data.record_count;

endmodule

// File: hw/rtl/kvp_checker.sv
// Port-level checker for the parser top level, attached by bind.
// Uses kvp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kvp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_record_begin,
   input logic [16:0] rsp_record_end,
   input logic [16:0] rsp_value_begin,
   input logic [63:0] rsp_key_number,
   input logic        rsp_is_selected,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_buffer_done
);
   import kvp_pkg::*;

   `KVP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `KVP_ASSERT_IMP(a_err_zeroed, clock, reset, rsp_valid && rsp_error_code != ERR_NONE,
      !rsp_is_selected && rsp_key_number == '0 && rsp_record_end == '0)
   `KVP_ASSERT_IMP(a_rec_span, clock, reset, rsp_valid && rsp_error_code == ERR_NONE,
      rsp_value_begin > {1'b0, rsp_record_begin} && rsp_value_begin <= rsp_record_end)
   `KVP_ASSERT_IMP(a_trunc_done, clock, reset, rsp_valid && rsp_error_code == ERR_TRUNCATED,
      rsp_buffer_done)

endmodule

bind kv_record_stream_parser_unit kvp_checker u_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for kv_record_stream_parser_unit: streams record buffers,
// predicts every result transaction and compares it as it leaves the block.
// Depends on kvp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module testbench;
   import kvp_pkg::*;

   typedef struct packed {
      logic [14:0]  record_index;
      logic [15:0]  record_begin;
      logic [16:0]  record_end;
      logic [16:0]  value_begin;
      logic         key_is_string;
      logic [6:0]   key_length;
      logic [63:0]  key_number;
      logic         is_selected;
      err_code_type error_code;
      logic         buffer_done;
      logic [15:0]  record_count;
   } record_summary_type;

   typedef enum {
      REC_ZERO_LEN, REC_LONG_LEN, REC_KEY_LONG, REC_NOISE, REC_GOOD
   } record_kind_type;

   localparam int STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [14:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = '0;
   logic        req_last_in_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [14:0] rsp_record_index;
   logic [15:0] rsp_record_begin;
   logic [16:0] rsp_record_end;
   logic [16:0] rsp_value_begin;
   logic        rsp_key_is_string;
   logic [6:0]  rsp_key_length;
   logic [63:0] rsp_key_number;
   logic        rsp_is_selected;
   logic [2:0]  rsp_error_code;
   logic        rsp_buffer_done;
   logic [15:0] rsp_record_count;

   kv_record_stream_parser_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_in        (req_byte_in),
      .req_last_in_buffer (req_last_in_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_record_index   (rsp_record_index),
      .rsp_record_begin   (rsp_record_begin),
      .rsp_record_end     (rsp_record_end),
      .rsp_value_begin    (rsp_value_begin),
      .rsp_key_is_string  (rsp_key_is_string),
      .rsp_key_length     (rsp_key_length),
      .rsp_key_number     (rsp_key_number),
      .rsp_is_selected    (rsp_is_selected),
      .rsp_error_code     (rsp_error_code),
      .rsp_buffer_done    (rsp_buffer_done),
      .rsp_record_count   (rsp_record_count)
   );

   always #5 clock = ~clock;

   // parser state mirrored by the predictor
   phase_type   ph;
   logic [27:0] len_acc;
   logic [2:0]  len_bytes;
   logic [27:0] payload_left;
   logic [16:0] pos;
   logic [16:0] rec_begin;
   logic [16:0] val_pos;
   logic [6:0]  key_len;
   logic        key_str;
   logic [6:0]  key_seen;
   logic [63:0] key_acc;
   logic [15:0] rec_count;
   logic [14:0] sel_index;

   record_summary_type expected_records[$];
   logic [7:0]         stream_bytes[$];
   int                 mismatches = 0;
   int                 sent_bytes = 0;
   int                 quiet_cycles = 0;
   int                 stall_left = 0;
   bit                 idle_on = 1'b0;

   function automatic void clear_record();
      ph = PH_LENGTH;
      len_acc = '0;
      len_bytes = '0;
      payload_left = '0;
      key_len = '0;
      key_str = 1'b0;
      key_seen = '0;
      key_acc = '0;
   endfunction

   function automatic void clear_buffer();
      clear_record();
      pos = '0;
      rec_begin = '0;
      val_pos = '0;
      rec_count = '0;
   endfunction

   function automatic record_summary_type error_summary(input err_code_type code,
                                                        input bit last);
      record_summary_type r;
      r = '0;
      r.record_index = rec_count[14:0];
      r.record_begin = rec_begin[15:0];
      r.error_code = code;
      r.buffer_done = last;
      r.record_count = rec_count;
      if (last) clear_buffer();
      else ph = PH_SKIP;
      return r;
   endfunction

   function automatic record_summary_type record_summary(input bit last);
      record_summary_type r;
      r.record_index = rec_count[14:0];
      r.record_begin = rec_begin[15:0];
      r.record_end = pos + 17'd1;
      r.value_begin = val_pos;
      r.key_is_string = key_str;
      r.key_length = key_len;
      r.key_number = key_str ? 64'd0 : key_acc;
      r.is_selected = (rec_count[14:0] == sel_index);
      r.error_code = ERR_NONE;
      r.buffer_done = last;
      if (rec_count != 16'hFFFF) rec_count++;
      r.record_count = rec_count;
      if (last) begin
         clear_buffer();
      end else begin
         clear_record();
         pos++;
      end
      return r;
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input bit last,
                                     output record_summary_type r);
      r = '0;
      if (ph == PH_SKIP) begin
         if (last) clear_buffer();
         return 1'b0;
      end
      if (ph == PH_LENGTH && len_bytes == 0) rec_begin = pos;
      if (pos >= MAX_BUF_BYTES) begin
         r = error_summary(ERR_BUF_LIMIT, last);
         return 1'b1;
      end
      case (ph)
         PH_LENGTH: begin
            len_acc = {len_acc[20:0], b[6:0]};
            len_bytes++;
            if (b[7]) begin
               if (len_bytes >= MAX_LENGTH_BYTES) begin
                  r = error_summary(ERR_BAD_LENGTH, last);
                  return 1'b1;
               end
            end else begin
               if (len_acc == 0) begin
                  r = error_summary(ERR_BAD_LENGTH, last);
                  return 1'b1;
               end
               payload_left = len_acc;
               ph = PH_HEADER;
            end
         end
         PH_HEADER: begin
            key_str = b[7];
            key_len = b[6:0];
            payload_left--;
            if (key_len > payload_left) begin
               r = error_summary(ERR_KEY_LONG, last);
               return 1'b1;
            end
            key_seen = '0;
            key_acc = '0;
            val_pos = pos + 17'd1 + key_len;
            if (payload_left == 0) begin
               r = record_summary(last);
               return 1'b1;
            end
            ph = (key_len != 0) ? PH_KEY : PH_VALUE;
         end
         PH_KEY: begin
            if (key_seen < KEY_ACC_BYTES) key_acc = {key_acc[55:0], b};
            key_seen++;
            payload_left--;
            if (payload_left == 0) begin
               r = record_summary(last);
               return 1'b1;
            end
            if (key_seen >= key_len) ph = PH_VALUE;
         end
         default: begin
            payload_left--;
            if (payload_left == 0) begin
               r = record_summary(last);
               return 1'b1;
            end
         end
      endcase
      if (last) begin
         r = error_summary(ERR_TRUNCATED, 1'b1);
         return 1'b1;
      end
      pos++;
      return 1'b0;
   endfunction

   function automatic string describe(input record_summary_type r);
      return $sformatf({"idx=%0d begin=%0d end=%0d vbegin=%0d str=%0b klen=%0d key=%h ",
                        "sel=%0b err=%0d done=%0b count=%0d"},
                       r.record_index, r.record_begin, r.record_end, r.value_begin,
                       r.key_is_string, r.key_length, r.key_number, r.is_selected,
                       r.error_code, r.buffer_done, r.record_count);
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit last);
      record_summary_type r;
      bit                 produced;
      if (idle_on && $urandom_range(0, 15) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      req_last_in_buffer <= last;
      do @(posedge clock); while (req_stall);
      sent_bytes++;
      produced = parse_byte(b, last, r);
      if (produced) expected_records.push_back(r);
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_bytes.size(); i++)
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
      stream_bytes.delete();
   endtask

   task automatic append_record(input int key_bytes, input int value_bytes, input bit str_key,
                                input int pad_groups);
      int total;
      int groups;
      int chunk;
      total = 1 + key_bytes + value_bytes;
      groups = 1;
      while (total >= (1 << (7 * groups))) groups++;
      groups = groups + pad_groups;
      if (groups > MAX_LENGTH_BYTES) groups = MAX_LENGTH_BYTES;
      for (int i = groups - 1; i >= 0; i--) begin
         chunk = total >> (7 * i);
         stream_bytes.push_back({i != 0, chunk[6:0]});
      end
      stream_bytes.push_back({str_key, key_bytes[6:0]});
      repeat (key_bytes + value_bytes) stream_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic set_selected_index(input int value);
      while (expected_records.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[14:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sel_index = value[14:0];
   endtask

   task automatic test_basic_records();
      idle_on = 1'b1;
      // header-only record, index 0 matches the reset selection
      stream_bytes.push_back(8'h01);
      stream_bytes.push_back(8'h00);
      append_record(9, 0, 1'b0, 0);
      append_record(3, 1, 1'b1, 0);
      append_record(0, 2, 1'b0, 1);
      send_stream();
      stream_bytes.push_back(8'h03);
      stream_bytes.push_back(8'h02);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'hFF);
      send_stream();
      req_valid <= 1'b0;
   endtask

   task automatic test_error_codes();
      set_selected_index(1);
      stream_bytes.push_back(8'h00);
      send_stream();
      stream_bytes.push_back(8'h01);
      stream_bytes.push_back(8'h80);
      stream_bytes.push_back(8'h85);
      stream_bytes.push_back(8'h80);
      stream_bytes.push_back(8'h80);
      stream_bytes.push_back(8'h80);
      stream_bytes.push_back(8'h12);
      stream_bytes.push_back(8'h34);
      send_stream();
      // key overflow on the closing byte wins over truncation
      stream_bytes.push_back(8'h03);
      stream_bytes.push_back(8'h05);
      send_stream();
      stream_bytes.push_back(8'h05);
      stream_bytes.push_back(8'h82);
      stream_bytes.push_back(8'h41);
      send_stream();
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(8'h80);
      stream_bytes.push_back(8'h80);
      stream_bytes.push_back(8'hFF);
      send_stream();
      req_valid <= 1'b0;
   endtask

   task automatic test_random_buffers(input int item_goal, input int index_value,
                                      input bit with_idle);
      int              target;
      int              pick;
      int              total;
      record_kind_type kind;
      set_selected_index(index_value);
      idle_on = with_idle;
      target = sent_bytes + item_goal;
      while (sent_bytes < target) begin
         repeat ($urandom_range(1, 6)) begin
            pick = $urandom_range(0, 19);
            kind = (pick < 4) ? record_kind_type'(pick) : REC_GOOD;
            case (kind)
               REC_ZERO_LEN: begin
                  if ($urandom_range(0, 1) == 1) stream_bytes.push_back(8'h80);
                  stream_bytes.push_back(8'h00);
               end
               REC_LONG_LEN: begin
                  repeat (MAX_LENGTH_BYTES) stream_bytes.push_back({1'b1, 7'($urandom)});
               end
               REC_KEY_LONG: begin
                  total = $urandom_range(1, 20);
                  stream_bytes.push_back(total[7:0]);
                  pick = $urandom_range(total, 127);
                  stream_bytes.push_back({$urandom_range(0, 1) == 1, pick[6:0]});
               end
               REC_NOISE: begin
                  repeat ($urandom_range(1, 6))
                     stream_bytes.push_back(8'($urandom_range(0, 255)));
               end
               default: begin
                  append_record(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(0, 10),
                                $urandom_range(0, 12), $urandom_range(0, 1) == 1,
                                ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
               end
            endcase
         end
         // cut the buffer short now and then
         if ($urandom_range(0, 7) == 0 && stream_bytes.size() > 1)
            repeat ($urandom_range(1, stream_bytes.size() - 1)) stream_bytes.pop_back();
         send_stream();
      end
      req_valid <= 1'b0;
   endtask

   task automatic finish_run();
      idle_on = 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   endtask

   always @(posedge clock) begin
      if (reset || !idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : result_check
      record_summary_type seen;
      record_summary_type want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            seen.record_index = rsp_record_index;
            seen.record_begin = rsp_record_begin;
            seen.record_end = rsp_record_end;
            seen.value_begin = rsp_value_begin;
            seen.key_is_string = rsp_key_is_string;
            seen.key_length = rsp_key_length;
            seen.key_number = rsp_key_number;
            seen.is_selected = rsp_is_selected;
            seen.error_code = err_code_type'(rsp_error_code);
            seen.buffer_done = rsp_buffer_done;
            seen.record_count = rsp_record_count;
            if (expected_records.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result: %s", describe(seen));
            end else begin
               want = expected_records.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result mismatch, expected %s", describe(want));
                     $display("                 actual   %s", describe(seen));
                  end
               end
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      sel_index = '0;
      clear_buffer();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_basic_records();
      test_error_codes();
      test_random_buffers(300, 2, 1'b1);
      test_random_buffers(300, $urandom_range(0, 4), 1'b1);
      test_random_buffers(200, 1, 1'b0);
      finish_run();
   end

endmodule
